### rtl/keyed_record_table_defines.svh
// Assertion macros for the keyed record table.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// Overlapping implication, sampled on the rising edge of clk, off during reset.
`define KRT_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("keyed_record_table: overlapping check failed");
// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define KRT_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("keyed_record_table: next-cycle check failed");
`else
`define KRT_ASSERT_IMP(label, cond, prop)
`define KRT_ASSERT_NXT(label, cond, prop)
`endif
`endif

### rtl/krt_pkg.sv
// Package for the keyed record table: record layout, operation and status codes,
// controller states and port widths. No dependencies.
package krt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IN_DATA_W   = 72;
    localparam int IN_USER_W   = 5;
    localparam int OUT_USER_W  = 2;
    // Fixed record fields in the output tdata, below the entry count.
    localparam int REC_W       = 50;

    typedef struct packed {
        logic [15:0] owner;
        logic [9:0]  capacity;
        logic [7:0]  credits;
        logic [15:0] id;
    } record_t;

    typedef enum logic [2:0] {
        F_ADD     = 3'd0,
        F_SEARCH  = 3'd1,
        F_UPDATE  = 3'd2,
        F_DEL_KEY = 3'd3,
        F_DEL_OLD = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        SEL_ID       = 2'd0,
        SEL_CREDITS  = 2'd1,
        SEL_CAPACITY = 2'd2,
        SEL_OWNER    = 2'd3
    } field_sel_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_OLDEST
    } state_t;

endpackage

### rtl/keyed_record_table.sv
// Keyed record table, top level; uses krt_pkg and keyed_record_table_defines.svh.
// Records live in one synchronous memory organized as a ring: logical position 0 (the newest)
// sits at the head pointer. Add, unused codes, add on a full table and the other operations on an
// empty table are answered directly; delete oldest reads the oldest record first; search and update
// scan from the newest record until the key matches or all records are read; delete by key scans
// the same way, then moves the newer records one place toward the oldest end. The single memory
// read port, one entry per cycle, paces the scans.
// The next transfer is taken only once the table is idle and the result register is free or
// being drained. Memory contents need no initialization after reset.
`include "keyed_record_table_defines.svh"

module keyed_record_table #(
    parameter int  ENTRIES    = krt_pkg::ENTRIES_DEF,
    localparam int CNT_W      = $clog2(ENTRIES + 1),
    localparam int OUT_DATA_W = ((krt_pkg::REC_W + CNT_W + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // key_id[15:0], credits[23:16], capacity[33:24], prof_id[49:34], value[65:50], zero fill
    input  logic [krt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[2:0], field_sel[4:3]
    input  logic [krt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // found_id[15:0], found_credits[23:16], found_capacity[33:24], found_prof_id[49:34],
    // entry_count above that, zero fill
    output logic [OUT_DATA_W-1:0]          m_axis_tdata,
    // status[1:0]
    output logic [krt_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import krt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W + 1)'(ENTRIES))
        begin
            sum = sum - (IDX_W + 1)'(ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Record memory.
    record_t        mem [ENTRIES];
    record_t        rd_data_reg;
    logic           mem_we;
    logic           mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    record_t        mem_wdata;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_pos_reg, rd_pos_next;

    // Captured operation.
    func_t            func_reg, func_next;
    logic [15:0]      key_reg, key_next;
    field_sel_t       sel_reg, sel_next;
    logic [15:0]      val_reg, val_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    record_t          out_rec_reg, out_rec_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             out_load;
    logic             out_free;

    // Input fields.
    func_t            in_func;
    field_sel_t       in_sel;
    record_t          in_rec;
    logic             in_accept;

    logic             hit;
    record_t          upd_rec;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] last_pos;
    logic             add_room;
    logic             shift_done;

    assign in_func         = func_t'(s_axis_tuser[2:0]);
    assign in_sel          = field_sel_t'(s_axis_tuser[4:3]);
    assign in_rec.id       = s_axis_tdata[15:0];
    assign in_rec.credits  = s_axis_tdata[23:16];
    assign in_rec.capacity = s_axis_tdata[33:24];
    assign in_rec.owner    = s_axis_tdata[49:34];

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign hit      = rd_pend_reg && (rd_data_reg.id == key_reg);
    assign head_dec = (head_reg == '0) ? IDX_W'(ENTRIES - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(ENTRIES - 1)) ? '0 : head_reg + 1'b1;
    assign last_pos = IDX_W'(count_reg - 1'b1);

    // Selected field overwritten, with saturation for the narrow fields.
    always_comb
    begin
        upd_rec = rd_data_reg;
        case (sel_reg)
            SEL_ID:       upd_rec.id = val_reg;
            SEL_CREDITS:  upd_rec.credits = (|val_reg[15:8]) ? 8'hFF : val_reg[7:0];
            SEL_CAPACITY: upd_rec.capacity = (|val_reg[15:10]) ? 10'h3FF : val_reg[9:0];
            SEL_OWNER:    upd_rec.owner = val_reg;
            default:      upd_rec = rd_data_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        rd_pos_next     = rd_pos_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        sel_next        = sel_reg;
        val_next        = val_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;
        mem_wdata       = in_rec;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;
        out_load        = 1'b0;
        out_status_next = STAT_OK;
        out_rec_next    = '0;
        out_count_next  = count_reg;
        s_axis_tready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = out_free;
                if (in_accept)
                begin
                    func_next = in_func;
                    key_next  = s_axis_tdata[15:0];
                    sel_next  = in_sel;
                    val_next  = s_axis_tdata[65:50];
                    case (in_func)
                        F_ADD:
                        begin
                            out_load = 1'b1;
                            if (count_reg == CNT_W'(ENTRIES))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = head_dec;
                                head_next      = head_dec;
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end
                        F_SEARCH, F_UPDATE, F_DEL_KEY:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                issue_next = '0;
                                state_next = S_SCAN;
                            end
                        end
                        F_DEL_OLD:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = phys(head_reg, last_pos);
                                state_next = S_OLDEST;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // One read issued per cycle; the compare sees that read's data in the following cycle.
                if (hit)
                begin
                    out_load     = 1'b1;
                    out_rec_next = rd_data_reg;
                    state_next   = S_IDLE;
                    case (func_reg)
                        F_UPDATE:
                        begin
                            mem_we       = 1'b1;
                            mem_waddr    = phys(head_reg, rd_pos_reg);
                            mem_wdata    = upd_rec;
                            out_rec_next = upd_rec;
                        end
                        F_DEL_KEY:
                        begin
                            out_count_next = count_reg - 1'b1;
                            issue_next     = CNT_W'(rd_pos_reg);
                            state_next     = S_SHIFT;
                        end
                        default:
                        begin
                            out_rec_next = rd_data_reg;
                        end
                    endcase
                end
                else if (issue_reg == count_reg)
                begin
                    out_load        = 1'b1;
                    out_status_next = STAT_NOTFOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = phys(head_reg, issue_reg[IDX_W-1:0]);
                    rd_pos_next  = issue_reg[IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Each newer record moves one place toward the oldest end, then the head
                // steps over the stale copy at the front.
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(head_reg, IDX_W'(rd_pos_reg + 1'b1));
                    mem_wdata = rd_data_reg;
                end
                if (issue_reg != '0)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = phys(head_reg, IDX_W'(issue_reg - 1'b1));
                    rd_pos_next  = IDX_W'(issue_reg - 1'b1);
                    rd_pend_next = 1'b1;
                    issue_next   = issue_reg - 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_OLDEST:
            begin
                out_load       = 1'b1;
                out_rec_next   = rd_data_reg;
                out_count_next = count_reg - 1'b1;
                count_next     = count_reg - 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= rd_pos_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        sel_reg    <= sel_next;
        val_reg    <= val_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_rec_reg    <= out_rec_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_count_reg, out_rec_reg});

    assign add_room   = in_accept && (in_func == F_ADD) && (count_reg != CNT_W'(ENTRIES));
    assign shift_done = (state_reg == S_SHIFT) && (state_next == S_IDLE);

    `KRT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `KRT_ASSERT_IMP(a_result_not_lost, out_load, out_free)
    `KRT_ASSERT_IMP(a_scan_in_range, mem_re && (state_reg == S_SCAN), issue_reg < count_reg)
    `KRT_ASSERT_NXT(a_add_grows, add_room, count_reg == $past(count_reg) + 1'b1)
    `KRT_ASSERT_NXT(a_shift_shrinks, shift_done, count_reg == $past(count_reg) - 1'b1)

endmodule
